FILE: src/wbps_pkg.sv
// Shared types and constants for the wildcard byte pattern scanner.
// No dependencies; imported by every module of the block.
`default_nettype none
package wbps_pkg;

  localparam int PATTERN_MAX_DEF = 16;
  localparam int ADDR_W          = 48;
  localparam int OFF_W           = 32;
  localparam int LEN_W           = 5;
  localparam int WORD_W          = 64;
  localparam int CFG_IDX_W       = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW    = 3'd0,
    REG_PATTERN_HIGH   = 3'd1,
    REG_WILDCARD_MASK  = 3'd2,
    REG_PATTERN_LENGTH = 3'd3,
    REG_MATCH_OFFSET   = 3'd4,
    REG_BASE_ADDRESS   = 3'd5
  } cfg_reg_t;

  // Per-cell settings handed from the top level to each compare cell.
  typedef struct packed {
    logic [7:0] pat_byte;
    logic       wild;
    logic       in_use;
  } cell_cfg_t;

endpackage
`default_nettype wire

FILE: src/wbps_cell.sv
// One compare cell of the shift-and chain: holds one partial-match bit.
// Depends on wbps_pkg for the cell settings struct.
`default_nettype none
module wbps_cell
  import wbps_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cell_cfg_t cell_cfg,
  input  wire logic [7:0] data_byte,
  input  wire logic      step,
  input  wire logic      prev_match,
  output logic           match_nxt,
  output logic           match_r
);

  logic eq;

  assign eq        = cell_cfg.wild || (cell_cfg.pat_byte == data_byte);
  assign match_nxt = prev_match && eq && cell_cfg.in_use;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (step) begin
      match_r <= match_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/wildcard_byte_pattern_scanner_unit.sv
// Top level of the wildcard byte pattern scanner: config registers, cell chain,
// result pipeline. Depends on wbps_pkg and wbps_cell.
//
// Takes one byte per clock on the in_ stream while in_tready is high and looks
// for the first place where the programmed pattern (up to PATTERN_MAX bytes,
// each byte optionally a wildcard) occurs. A row of PATTERN_MAX compare cells
// holds the shift-and partial-match vector; every accepted byte advances all
// cells at once, so a new byte can be taken every cycle unless in_tready is
// low. A result (found with its address, or not found when the byte marked
// tlast passes) is registered first with its match start, then in the output
// register with the address sum base + start + offset, before it reaches out_.
// Bytes after a result are dropped until a byte with tuser set starts a new
// scan. in_tready falls only while a result is held in both stages with
// out_tready low. Config writes are always taken (cfg_ready is tied high) and should be issued while idle.
`default_nettype none
module wildcard_byte_pattern_scanner_unit
  import wbps_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // in_tdata: [7:0] data_byte
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [7:0]           in_tdata,
  // in_tuser: [0] first_byte
  input  wire logic [0:0]           in_tuser,
  input  wire logic                 in_tlast,
  // out_tdata: [47:0] match_address
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [ADDR_W-1:0]         out_tdata,
  // out_tuser: [0] found
  output logic [0:0]                out_tuser,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_data
);

  // Configuration registers
  logic [WORD_W-1:0] pat_low_r, pat_high_r;
  logic [15:0]       wild_mask_r;
  logic [LEN_W-1:0]  pat_len_r;
  logic [OFF_W-1:0]  match_off_r;
  logic [ADDR_W-1:0] base_addr_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r   <= '0;
      pat_high_r  <= '0;
      wild_mask_r <= '0;
      pat_len_r   <= LEN_W'(1);
      match_off_r <= '0;
      base_addr_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PATTERN_LOW:    pat_low_r   <= cfg_data;
        REG_PATTERN_HIGH:   pat_high_r  <= cfg_data;
        REG_WILDCARD_MASK:  wild_mask_r <= cfg_data[15:0];
        REG_PATTERN_LENGTH: pat_len_r   <= cfg_data[LEN_W-1:0];
        REG_MATCH_OFFSET:   match_off_r <= cfg_data[OFF_W-1:0];
        REG_BASE_ADDRESS:   base_addr_r <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective length: zero acts as one, clamp to the cell count
  logic [LEN_W-1:0] len_eff;
  always_comb begin
    if (pat_len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (pat_len_r > LEN_W'(PATTERN_MAX)) begin
      len_eff = LEN_W'(PATTERN_MAX);
    end else begin
      len_eff = pat_len_r;
    end
  end

  // Handshake and pipeline control
  logic              s1_valid_r, s1_found_r;
  logic [ADDR_W-1:0] s1_start_r;
  logic              out_valid_r, out_found_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic              out_free, in_xfer;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || out_free;
  assign in_xfer   = in_tvalid && in_tready;

  // Scan state
  logic              scan_done_r;
  logic [ADDR_W-1:0] pos_r;
  logic              first, active, step;
  logic [ADDR_W-1:0] pos_eff;

  assign first   = in_tuser[0];
  assign active  = first || !scan_done_r;
  assign step    = in_xfer && active;
  assign pos_eff = first ? '0 : pos_r;

  // Cell chain
  logic [PATTERN_MAX-1:0] match_nxt, match_r;
  logic [2*WORD_W-1:0]    pat_all;
  logic                   hit;

  assign pat_all = {pat_high_r, pat_low_r};

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    cell_cfg_t cc;
    logic      prev;
    assign cc.pat_byte = pat_all[8*i +: 8];
    assign cc.wild     = wild_mask_r[i];
    assign cc.in_use   = (LEN_W'(i) < len_eff);
    if (i == 0) begin : g_head
      assign prev = 1'b1;
    end else begin : g_link
      assign prev = !first && match_r[i-1];
    end
    wbps_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cell_cfg   (cc),
      .data_byte  (in_tdata),
      .step       (step),
      .prev_match (prev),
      .match_nxt  (match_nxt[i]),
      .match_r    (match_r[i])
    );
  end

  // Select the cell at the pattern's end
  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (LEN_W'(i + 1) == len_eff) begin
        hit = hit | match_nxt[i];
      end
    end
  end

  logic scan_done_nxt;
  logic [ADDR_W-1:0] pos_nxt;
  assign pos_nxt       = pos_eff + ADDR_W'(1);
  assign scan_done_nxt = hit || in_tlast;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_done_r <= 1'b0;
      pos_r       <= '0;
    end else if (step) begin
      scan_done_r <= scan_done_nxt;
      pos_r       <= pos_nxt;
    end
  end

  // Stage 1: match start position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= step && scan_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && step) begin
      s1_found_r <= hit;
      s1_start_r <= pos_eff - ADDR_W'(len_eff - LEN_W'(1));
    end
  end

  // Stage 2: address sum into the output register
  logic [ADDR_W-1:0] addr_sum;
  assign addr_sum = base_addr_r + s1_start_r
                    + {{(ADDR_W-OFF_W){match_off_r[OFF_W-1]}}, match_off_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r) begin
      out_found_r <= s1_found_r;
      out_addr_r  <= s1_found_r ? addr_sum : '0;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_addr_r;
  assign out_tuser[0] = out_found_r;

endmodule
`default_nettype wire

FILE: src/wbps_checker.sv
// Port-level checks for the wildcard byte pattern scanner, bound to the top.
// Depends on wbps_pkg for widths.
`default_nettype none
module wbps_checker
  import wbps_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_tready,
  input wire logic              out_tvalid,
  input wire logic              out_tready,
  input wire logic [ADDR_W-1:0] out_tdata,
  input wire logic [0:0]        out_tuser
);

  // A stalled result transfer holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Not-found results carry a zero address
  a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("not-found result with nonzero address");

  // Input backpressure only while the output is stalled
  a_bp_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

endmodule

bind wildcard_byte_pattern_scanner_unit wbps_checker u_wbps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

FILE: tb/tb_wildcard_byte_pattern_scanner_unit.sv
// Self-checking testbench for wildcard_byte_pattern_scanner_unit.
// Depends on wbps_pkg. A scoreboard class predicts each scan result from the
// accepted bytes and register writes, then checks the out_ stream against it.
module tb_wildcard_byte_pattern_scanner_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import wbps_pkg::*;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] addr;
  } scan_result_t;

  class scan_scoreboard;
    bit [127:0]       pattern_bytes;
    bit [15:0]        wild_bits;
    bit [LEN_W-1:0]   len_field;
    bit [OFF_W-1:0]   offset;
    bit [ADDR_W-1:0]  base;
    bit [15:0]        partial;
    bit [ADDR_W-1:0]  position;
    bit               done;
    scan_result_t     expected_results[$];
    int               errors;
    int               consumed;

    function new();
      pattern_bytes = '0;
      wild_bits     = '0;
      len_field     = LEN_W'(1);
      offset        = '0;
      base          = '0;
      partial       = '0;
      position      = '0;
      done          = 1'b0;
      errors        = 0;
      consumed      = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, bit [WORD_W-1:0] d);
      case (idx)
        REG_PATTERN_LOW:    pattern_bytes[63:0]   = d;
        REG_PATTERN_HIGH:   pattern_bytes[127:64] = d;
        REG_WILDCARD_MASK:  wild_bits             = d[15:0];
        REG_PATTERN_LENGTH: len_field             = d[LEN_W-1:0];
        REG_MATCH_OFFSET:   offset                = d[OFF_W-1:0];
        REG_BASE_ADDRESS:   base                  = d[ADDR_W-1:0];
        default: ;
      endcase
    endfunction

    // Advance the shift-and vector by one accepted byte.
    function void note_byte(bit [7:0] d, bit first, bit last);
      int            len;
      bit [15:0]     eq;
      bit [15:0]     nxt;
      bit [ADDR_W-1:0] start;
      scan_result_t  r;
      if (first) begin
        partial  = '0;
        position = '0;
        done     = 1'b0;
      end
      if (done) return;
      consumed++;
      len = (len_field == 0) ? 1 : ((len_field > 16) ? 16 : int'(len_field));
      eq = '0;
      for (int i = 0; i < len; i++) begin
        if (wild_bits[i] || pattern_bytes[i*8 +: 8] == d) eq[i] = 1'b1;
      end
      nxt = ((partial << 1) | 16'd1) & eq;
      partial = nxt;
      if (nxt[len-1]) begin
        start = position - ADDR_W'(len - 1);
        r.found = 1'b1;
        r.addr  = base + start + {{(ADDR_W-OFF_W){offset[OFF_W-1]}}, offset};
        expected_results.push_back(r);
        done = 1'b1;
        position = position + 1'b1;
        return;
      end
      position = position + 1'b1;
      if (last) begin
        r.found = 1'b0;
        r.addr  = '0;
        expected_results.push_back(r);
        done = 1'b1;
      end
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic found, logic [ADDR_W-1:0] addr);
      scan_result_t e;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result found=%b addr=%h", found, addr));
        return;
      end
      e = expected_results.pop_front();
      if (found !== e.found)
        report_mismatch($sformatf("found: got %b, want %b", found, e.found));
      if (addr !== e.addr)
        report_mismatch($sformatf("match_address: got %h, want %h", addr, e.addr));
    endtask
  endclass

  localparam int ITEM_TARGET = 2000;
  localparam int HOLD_CYCLES = 80;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [7:0]           in_tdata;
  logic [0:0]           in_tuser;
  logic                 in_tlast;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [ADDR_W-1:0]    out_tdata;
  logic [0:0]           out_tuser;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_data;

  scan_scoreboard sb = new();

  int         in_idle_pct;
  int         out_idle_pct;
  bit         hold_off_request;
  bit [127:0] cur_pat;
  bit [15:0]  cur_mask;
  int         cur_len;

  wildcard_byte_pattern_scanner_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) sb.write_reg(cfg_reg_t'(cfg_index), cfg_data);
    if (rst_n && in_tvalid && in_tready) sb.note_byte(in_tdata, in_tuser[0], in_tlast);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser[0], out_tdata);
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_request) begin
        out_tready <= 1'b0;
        hold_off_request = 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(0, 99) >= out_idle_pct);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("wildcard_byte_pattern_scanner_unit regression: fail");
    $finish;
  end

  task send_byte(input bit [7:0] d, input bit first, input bit last);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= first;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task put_reg(input cfg_reg_t idx, input bit [WORD_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Upper bits beyond each register's width carry junk; the block must drop them.
  task set_config(input bit [63:0] lo, input bit [63:0] hi, input bit [15:0] mask,
                  input bit [LEN_W-1:0] len, input bit [OFF_W-1:0] off,
                  input bit [ADDR_W-1:0] base);
    bit [63:0] junk;
    junk = {$urandom, $urandom};
    put_reg(REG_PATTERN_LOW, lo);
    put_reg(REG_PATTERN_HIGH, hi);
    put_reg(REG_WILDCARD_MASK, {junk[63:16], mask});
    put_reg(REG_PATTERN_LENGTH, {junk[63:LEN_W], len});
    put_reg(REG_MATCH_OFFSET, {junk[63:OFF_W], off});
    put_reg(REG_BASE_ADDRESS, {junk[63:ADDR_W], base});
    cfg_valid <= 1'b0;
    cur_pat  = {hi, lo};
    cur_mask = mask;
    cur_len  = (len == 0) ? 1 : ((len > 16) ? 16 : int'(len));
  endtask

  task new_random_config();
    bit [LEN_W-1:0]  len;
    bit [15:0]       mask;
    bit [OFF_W-1:0]  off;
    bit [ADDR_W-1:0] base;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: len = LEN_W'($urandom_range(1, 4));
      6, 7:             len = LEN_W'($urandom_range(5, 15));
      8:                len = LEN_W'(16);
      default:          len = ($urandom_range(0, 1) == 0) ? LEN_W'(0)
                                                          : LEN_W'($urandom_range(17, 31));
    endcase
    case ($urandom_range(0, 7))
      0, 1, 2, 3: mask = '0;
      4, 5:       mask = 16'($urandom & $urandom & $urandom);
      6:          mask = 16'($urandom);
      default:    mask = 16'hFFFF;
    endcase
    case ($urandom_range(0, 7))
      0:       off = 32'h8000_0000;
      1:       off = 32'h7FFF_FFFF;
      2:       off = '0;
      3:       off = '1;
      default: off = $urandom;
    endcase
    case ($urandom_range(0, 5))
      0:       base = '0;
      1:       base = '1;
      default: base = ADDR_W'({$urandom, $urandom});
    endcase
    set_config({$urandom, $urandom}, {$urandom, $urandom}, mask, len, off, base);
  endtask

  // Wait out every expected result plus the two-stage result pipeline.
  task drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // One scan of random bytes biased toward pattern bytes, usually with the
  // pattern planted once. A split scan is reprogrammed halfway through.
  task run_scan(input bit split);
    bit [7:0] scan_bytes[$];
    int       n;
    int       at;
    bit       cont;
    bit       first;
    bit       last;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 20);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1) == 0) scan_bytes.push_back(8'($urandom));
      else scan_bytes.push_back(cur_pat[$urandom_range(0, cur_len - 1)*8 +: 8]);
    end
    if ($urandom_range(0, 3) != 0 && n >= cur_len) begin
      at = $urandom_range(0, n - cur_len);
      for (int j = 0; j < cur_len; j++)
        scan_bytes[at+j] = cur_mask[j] ? 8'($urandom) : cur_pat[j*8 +: 8];
    end
    cont = ($urandom_range(0, 19) == 0);
    for (int i = 0; i < n; i++) begin
      first = (i == 0) && !cont;
      last  = (i == n - 1);
      if ($urandom_range(0, 29) == 0) begin
        first = 1'($urandom);
        last  = 1'($urandom);
      end
      if (split && i > 0 && i == n / 2) begin
        drain();
        new_random_config();
      end
      send_byte(scan_bytes[i], first, last);
    end
  endtask

  initial begin
    bit pressure_done;
    int saved_pct;
    rst_n            <= 1'b0;
    in_tvalid        <= 1'b0;
    in_tdata         <= '0;
    in_tuser         <= '0;
    in_tlast         <= 1'b0;
    cfg_valid        <= 1'b0;
    cfg_index        <= REG_PATTERN_LOW;
    cfg_data         <= '0;
    hold_off_request = 1'b0;
    pressure_done    = 1'b0;
    in_idle_pct      = 21;
    out_idle_pct     = 72;
    cur_pat          = '0;
    cur_mask         = '0;
    cur_len          = 1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Scan is live straight out of reset: zero byte matches at position 2,
    // then the trailing byte is dropped.
    send_byte(8'h55, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    drain();

    // Length zero acts as one; base zero with offset -1 wraps the address.
    set_config(64'hAB, 64'h0, 16'h0, 5'd0, 32'hFFFF_FFFF, 48'h0);
    send_byte(8'hAB, 1'b1, 1'b1);
    send_byte(8'h12, 1'b1, 1'b1);
    drain();

    // Oversized length clamps to 16; full-length match lands on the last byte.
    set_config(64'h00FF_00FF_00FF_00FF, 64'hFF00_FF00_FF00_FF00, 16'h8001, 5'd31,
               32'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF);
    for (int j = 0; j < 16; j++) begin
      send_byte((j == 0) ? 8'h5A : ((j == 15) ? 8'hA5 : cur_pat[j*8 +: 8]),
                j == 0, j == 15);
    end

    while (sb.consumed < ITEM_TARGET) begin
      if (sb.consumed < ITEM_TARGET / 3) begin
        in_idle_pct  = 21;
        out_idle_pct = 72;
      end else if (sb.consumed < 2 * ITEM_TARGET / 3) begin
        in_idle_pct  = 72;
        out_idle_pct = 21;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      drain();
      new_random_config();
      if (!pressure_done && sb.consumed >= ITEM_TARGET / 2) begin
        // Single-byte scans each give a result; hold the receiver so they pile up.
        pressure_done    = 1'b1;
        saved_pct        = in_idle_pct;
        in_idle_pct      = 0;
        hold_off_request = 1'b1;
        repeat (40) send_byte(8'($urandom), 1'b1, 1'b1);
        in_idle_pct      = saved_pct;
      end
      repeat ($urandom_range(1, 6)) run_scan($urandom_range(0, 9) == 0);
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("wildcard_byte_pattern_scanner_unit regression: pass");
    end else begin
      $display("wildcard_byte_pattern_scanner_unit regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
src/wbps_pkg.sv
src/wbps_cell.sv
src/wildcard_byte_pattern_scanner_unit.sv
src/wbps_checker.sv
tb/tb_wildcard_byte_pattern_scanner_unit.sv
